@@ hdl/ptd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptd_pkg: shared types and constants of the periodic task dispatcher
// opcodes, status codes, slot modes and controller command/status structs
// ---------------------------------------------------------------------------
package ptd_pkg;

  localparam int SlotCountDef  = 16;
  localparam int PrioLevelsDef = 4;

  typedef enum logic [3:0] {
    OP_TICK     = 4'd0,
    OP_ADD      = 4'd1,
    OP_REMOVE   = 4'd2,
    OP_SUSPEND  = 4'd3,
    OP_RESUME   = 4'd4,
    OP_SET_PER  = 4'd5,
    OP_SET_PRIO = 4'd6,
    OP_DISPATCH = 4'd7,
    OP_DONE     = 4'd8
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_FREE  = 3'd1,
    ST_BAD_SLOT = 3'd2,
    ST_NONE_DUE = 3'd3,
    ST_NOT_RUN  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MODE_READY     = 2'd0,
    MODE_RUNNING   = 2'd1,
    MODE_SUSPENDED = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DONE_RD,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the input transaction
    logic start;  // start of walk: load walk position
    logic step;   // evaluate one walk position
    logic exec;   // opcodes run in one step
    logic done_rd;// done: read peak and run time
    logic finish; // close out the transaction result
  } ptd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_end; // walk reached its last position or, but for tick, found a slot
    logic is_walk;  // opcode needs a walk over slots
    logic is_done;  // opcode is done with a task running
  } ptd_sts_t;

endpackage

@@ hdl/ptd_stream_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptd_in_if / ptd_out_if: valid/ready channels of the dispatcher
// input opcodes and result transactions
// ---------------------------------------------------------------------------
interface ptd_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [3:0]  slot;
  logic [31:0] period_ticks;
  logic [1:0]  prio_level;
  modport source (output valid, opcode, slot, period_ticks, prio_level, input ready);
  modport sink (input valid, opcode, slot, period_ticks, prio_level, output ready);
endinterface

interface ptd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  result_slot;
  logic [31:0] run_ticks;
  logic [31:0] peak_run_ticks;
  logic [31:0] clock_now;
  modport source (output valid, status, result_slot, run_ticks, peak_run_ticks, clock_now,
                  input ready);
  modport sink (input valid, status, result_slot, run_ticks, peak_run_ticks, clock_now,
                output ready);
endinterface

@@ hdl/ptd_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptd_ctrl: transaction sequencer
// accepts one transaction, runs the walk or single-step command, holds result
// ---------------------------------------------------------------------------
module ptd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ptd_pkg::ptd_cmd_t cmd,
  input  ptd_pkg::ptd_sts_t sts
);

  ptd_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ptd_pkg::S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ptd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ptd_pkg::S_EXEC;
        end
      end
      ptd_pkg::S_EXEC: begin
        if (sts.is_walk) begin
          cmd.start  = 1'b1;
          state_next = ptd_pkg::S_WALK;
        end else if (sts.is_done) begin
          cmd.done_rd = 1'b1;
          state_next  = ptd_pkg::S_DONE_RD;
        end else begin
          cmd.exec   = 1'b1;
          state_next = ptd_pkg::S_OUT;
        end
      end
      ptd_pkg::S_WALK: begin
        cmd.step = 1'b1;
        if (sts.walk_end) state_next = ptd_pkg::S_DONE_RD;
      end
      ptd_pkg::S_DONE_RD: begin
        cmd.finish = 1'b1;
        state_next = ptd_pkg::S_OUT;
      end
      ptd_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ptd_pkg::S_IDLE;
      end
      default: state_next = ptd_pkg::S_IDLE;
    endcase
  end

endmodule

@@ hdl/ptd_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptd_datapath: slot table, clock and scan state
// walks slots one per cycle for tick, add and dispatch
// ---------------------------------------------------------------------------
module ptd_datapath #(
  parameter int SLOT_COUNT  = ptd_pkg::SlotCountDef,
  parameter int PRIO_LEVELS = ptd_pkg::PrioLevelsDef
) (
  input  logic              clk,
  input  logic              rst,
  input  ptd_pkg::ptd_cmd_t cmd,
  output ptd_pkg::ptd_sts_t sts,
  input  logic [3:0]        opcode,
  input  logic [3:0]        slot,
  input  logic [31:0]       period_ticks,
  input  logic [1:0]        prio_level,
  output logic [2:0]        status,
  output logic [3:0]        result_slot,
  output logic [31:0]       run_ticks,
  output logic [31:0]       peak_run_ticks,
  output logic [31:0]       clock_now
);

  localparam int PosCount = PRIO_LEVELS * 16;

  // captured transaction
  logic [3:0]  op_q, slot_q;
  logic [31:0] per_q;
  logic [1:0]  prio_q;

  // global state
  logic [31:0] clock_count, run_begin;
  logic [15:0] used_mask, due_mask;
  logic        run_none;
  logic [3:0]  run_slot;
  logic        scan_act;
  logic [5:0]  scan_pos;

  // slot table; mode in flops, the rest payload
  logic [1:0]  slot_mode [16];
  logic [31:0] slot_period [16];
  logic [31:0] slot_last [16];
  logic [1:0]  slot_prio [16];
  logic [31:0] slot_peak [16];

  // walk state
  logic [6:0]  pos;
  logic        found;
  logic [3:0]  found_slot;
  logic [31:0] peak_rd, run_q;

  logic        bad;
  logic [3:0]  k;
  logic [1:0]  lvl;
  logic        hit;
  logic [31:0] elapsed;
  logic [6:0]  walk_last;
  logic        scan_go;

  assign bad = (op_q >= 4'(ptd_pkg::OP_REMOVE)) && (op_q <= 4'(ptd_pkg::OP_SET_PRIO))
               && (5'(slot_q) >= 5'(SLOT_COUNT));
  assign k       = pos[3:0];
  assign lvl     = pos[5:4];
  assign elapsed = clock_count - slot_last[k];
  assign scan_go = run_none && (scan_act || (due_mask != 16'd0));

  // per-position hit for the active walk
  always_comb begin
    hit       = 1'b0;
    walk_last = 7'(SLOT_COUNT - 1);
    case (op_q)
      4'(ptd_pkg::OP_TICK):
        hit = used_mask[k] && slot_mode[k] == ptd_pkg::MODE_READY
              && elapsed >= slot_period[k];
      4'(ptd_pkg::OP_ADD): hit = !used_mask[k];
      default: begin
        walk_last = 7'(PosCount - 1);
        hit = (5'(k) < 5'(SLOT_COUNT)) && used_mask[k] && due_mask[k]
              && slot_prio[k] == lvl && slot_mode[k] == ptd_pkg::MODE_READY;
      end
    endcase
  end

  always_comb begin
    sts.is_walk  = !bad && (op_q == 4'(ptd_pkg::OP_TICK) || op_q == 4'(ptd_pkg::OP_ADD)
                   || (op_q == 4'(ptd_pkg::OP_DISPATCH) && scan_go));
    sts.is_done  = !bad && op_q == 4'(ptd_pkg::OP_DONE) && !run_none;
    sts.walk_end = (pos == walk_last)
                   || (hit && op_q != 4'(ptd_pkg::OP_TICK));
  end

  assign clock_now = clock_count;

  // sequential state update
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= opcode; slot_q <= slot; per_q <= period_ticks; prio_q <= prio_level;
    end
    if (cmd.start) begin
      pos   <= (op_q == 4'(ptd_pkg::OP_DISPATCH) && scan_act) ? {1'b0, scan_pos} : 7'd0;
      found <= 1'b0;
      if (op_q == 4'(ptd_pkg::OP_TICK)) clock_count <= clock_count + 32'd1;
    end
    if (cmd.step) begin
      pos <= pos + 7'd1;
      if (hit) begin
        found_slot <= k;
        found      <= 1'b1;
        if (op_q == 4'(ptd_pkg::OP_TICK)) due_mask[k] <= 1'b1;
        else if (op_q == 4'(ptd_pkg::OP_ADD)) begin
          slot_period[k] <= per_q;
          slot_last[k]   <= clock_count;
          slot_peak[k]   <= 32'd0;
          slot_mode[k]   <= ptd_pkg::MODE_READY;
          slot_prio[k]   <= prio_q;
          used_mask[k]   <= 1'b1;
          due_mask[k]    <= 1'b0;
        end else begin
          due_mask[k]  <= 1'b0;
          slot_mode[k] <= ptd_pkg::MODE_RUNNING;
          run_slot     <= k;
          run_none     <= 1'b0;
          run_begin    <= clock_count;
        end
      end
    end
    if (cmd.done_rd) begin
      peak_rd <= slot_peak[run_slot];
      run_q   <= clock_count - run_begin;
    end
    if (cmd.exec) begin
      status <= bad ? 3'(ptd_pkg::ST_BAD_SLOT) : 3'(ptd_pkg::ST_OK);
      result_slot <= 4'd0; run_ticks <= 32'd0; peak_run_ticks <= 32'd0;
      if (!bad) begin
        case (op_q)
          4'(ptd_pkg::OP_REMOVE): begin
            used_mask[slot_q] <= 1'b0; due_mask[slot_q] <= 1'b0;
            slot_mode[slot_q] <= ptd_pkg::MODE_SUSPENDED;
          end
          4'(ptd_pkg::OP_SUSPEND): begin
            slot_mode[slot_q] <= ptd_pkg::MODE_SUSPENDED; due_mask[slot_q] <= 1'b0;
          end
          4'(ptd_pkg::OP_RESUME): begin
            slot_mode[slot_q] <= ptd_pkg::MODE_READY; slot_last[slot_q] <= clock_count;
          end
          4'(ptd_pkg::OP_SET_PER): begin
            slot_period[slot_q] <= per_q; slot_last[slot_q] <= clock_count;
          end
          4'(ptd_pkg::OP_SET_PRIO): slot_prio[slot_q] <= prio_q;
          4'(ptd_pkg::OP_DISPATCH):
            if (!run_none) result_slot <= run_slot;
            else status <= 3'(ptd_pkg::ST_NONE_DUE);
          4'(ptd_pkg::OP_DONE): status <= 3'(ptd_pkg::ST_NOT_RUN);
          default: ;
        endcase
      end
    end
    if (cmd.finish) begin
      status <= 3'(ptd_pkg::ST_OK);
      result_slot <= 4'd0; run_ticks <= 32'd0; peak_run_ticks <= 32'd0;
      case (op_q)
        4'(ptd_pkg::OP_ADD):
          if (found) result_slot <= found_slot;
          else status <= 3'(ptd_pkg::ST_NO_FREE);
        4'(ptd_pkg::OP_DISPATCH): begin
          if (found) result_slot <= found_slot;
          else status <= 3'(ptd_pkg::ST_NONE_DUE);
          if (found && pos < 7'(PosCount)) begin
            scan_act <= 1'b1; scan_pos <= pos[5:0];
          end else scan_act <= 1'b0;
        end
        4'(ptd_pkg::OP_DONE): begin
          result_slot <= run_slot;
          run_ticks   <= run_q;
          peak_run_ticks <= (run_q > peak_rd) ? run_q : peak_rd;
          if (run_q > peak_rd) slot_peak[run_slot] <= run_q;
          slot_last[run_slot] <= clock_count;
          if (slot_mode[run_slot] == ptd_pkg::MODE_RUNNING)
            slot_mode[run_slot] <= ptd_pkg::MODE_READY;
          run_none <= 1'b1;
        end
        default: ;
      endcase
    end
    if (rst) begin
      clock_count <= '0; used_mask <= '0; due_mask <= '0;
      run_begin <= '0; run_none <= 1'b1; run_slot <= '0;
      scan_act <= 1'b0; scan_pos <= '0;
      for (int i = 0; i < 16; i++) slot_mode[i] <= ptd_pkg::MODE_SUSPENDED;
    end
  end

endmodule

@@ hdl/periodic_task_dispatcher.sv @@
`timescale 1ns / 1ps
// operation: one transaction at a time; tick walks all SLOT_COUNT slots, add up to
// SLOT_COUNT slots and dispatch up to 16*PRIO_LEVELS positions, one slot per cycle;
// done with a task running reads the peak first, other opcodes run in a single step,
// and each result is held until taken before the next transaction is accepted
// reset: synchronous rst clears the clock, masks, modes and scan; no clearing pass
// ---------------------------------------------------------------------------
// periodic_task_dispatcher: top level
// opcode-driven periodic task slot table with priority dispatch scan
// ---------------------------------------------------------------------------
module periodic_task_dispatcher #(
  parameter int SLOT_COUNT  = ptd_pkg::SlotCountDef,
  parameter int PRIO_LEVELS = ptd_pkg::PrioLevelsDef
) (
  input logic     clk,
  input logic     rst,
  ptd_in_if.sink  in_ch,
  ptd_out_if.source out_ch
);

  ptd_pkg::ptd_cmd_t cmd;
  ptd_pkg::ptd_sts_t sts;

  // sequencer
  ptd_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  // slot table and walk
  ptd_datapath #(.SLOT_COUNT(SLOT_COUNT), .PRIO_LEVELS(PRIO_LEVELS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .opcode(in_ch.opcode), .slot(in_ch.slot),
    .period_ticks(in_ch.period_ticks), .prio_level(in_ch.prio_level),
    .status(out_ch.status), .result_slot(out_ch.result_slot),
    .run_ticks(out_ch.run_ticks), .peak_run_ticks(out_ch.peak_run_ticks),
    .clock_now(out_ch.clock_now)
  );

endmodule

@@ hdl/ptd_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptd_checker: port-level checks of the dispatcher
// one transaction in flight, result codes in range
// ---------------------------------------------------------------------------
module ptd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] clock_now
);

  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(clock_now))
    else $error("result changed while stalled");

  // no input taken while a result waits
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= 3'(ptd_pkg::ST_NOT_RUN)) else $error("bad status code");

  // idle the cycle after a result
  a_clock: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready) else $error("not idle after result");

  // busy the cycle after an accepted transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("input taken twice in a row");

endmodule

bind periodic_task_dispatcher ptd_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .clock_now(out_ch.clock_now)
);

@@ bench/periodic_task_dispatcher_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// periodic_task_dispatcher_test: self-checking bench of the task dispatcher
// drives opcode transactions with random gaps and output stalls, predicts
// every result with an in-bench model of the slot table and compares fields
// ---------------------------------------------------------------------------
module periodic_task_dispatcher_test;

  localparam int NSLOT = ptd_pkg::SlotCountDef;
  localparam int NPRIO = ptd_pkg::PrioLevelsDef;

  typedef struct {
    ptd_pkg::status_t status;
    logic [3:0]  rslot;
    logic [31:0] run;
    logic [31:0] peak;
    logic [31:0] now;
  } outcome_t;

  logic clk;
  logic rst;

  ptd_in_if  in_ch ();
  ptd_out_if out_ch ();

  periodic_task_dispatcher uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the slot table
  logic [31:0] tick_count;
  logic [15:0] in_use;
  logic [15:0] pending;
  ptd_pkg::mode_t task_mode [NSLOT];
  logic [31:0] task_period [NSLOT];
  logic [31:0] task_start [NSLOT];
  logic [1:0]  task_prio [NSLOT];
  logic [31:0] task_peak [NSLOT];
  logic [31:0] run_from;
  logic        busy;
  logic [3:0]  busy_slot;
  logic        scan_on;
  logic [6:0]  scan_pos;

  outcome_t pending_results [$];
  int       fails;
  bit       quiet;      // no idling on either side
  int       rx_hold;    // long receiver stall, counted by the receiver

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // predicted outcome of one transaction, updating the shadow table
  function automatic outcome_t dispatcher_step(logic [3:0] op, logic [3:0] s,
                                               logic [31:0] per, logic [1:0] pr);
    outcome_t r;
    bit       found;
    int       p;
    int       lvl;
    int       k;
    r.status = ptd_pkg::ST_OK;
    r.rslot  = '0;
    r.run    = '0;
    r.peak   = '0;
    found    = 1'b0;
    case (op)
      ptd_pkg::OP_TICK: begin
        tick_count = tick_count + 1;
        for (int i = 0; i < NSLOT; i++)
          if (in_use[i] && task_mode[i] == ptd_pkg::MODE_READY &&
              (tick_count - task_start[i]) >= task_period[i])
            pending[i] = 1'b1;
      end
      ptd_pkg::OP_ADD: begin
        r.status = ptd_pkg::ST_NO_FREE;
        for (int i = 0; i < NSLOT; i++) begin
          if (!in_use[i]) begin
            task_period[i] = per;
            task_start[i]  = tick_count;
            task_peak[i]   = '0;
            task_mode[i]   = ptd_pkg::MODE_READY;
            task_prio[i]   = pr;
            in_use[i]      = 1'b1;
            pending[i]     = 1'b0;
            r.status       = ptd_pkg::ST_OK;
            r.rslot        = 4'(i);
            break;
          end
        end
      end
      ptd_pkg::OP_REMOVE: begin
        in_use[s]    = 1'b0;
        pending[s]   = 1'b0;
        task_mode[s] = ptd_pkg::MODE_SUSPENDED;
      end
      ptd_pkg::OP_SUSPEND: begin
        task_mode[s] = ptd_pkg::MODE_SUSPENDED;
        pending[s]   = 1'b0;
      end
      ptd_pkg::OP_RESUME: begin
        task_mode[s]  = ptd_pkg::MODE_READY;
        task_start[s] = tick_count;
      end
      ptd_pkg::OP_SET_PER: begin
        task_period[s] = per;
        task_start[s]  = tick_count;
      end
      ptd_pkg::OP_SET_PRIO: task_prio[s] = pr;
      ptd_pkg::OP_DISPATCH: begin
        if (busy) begin
          r.rslot = busy_slot;
        end else if (!scan_on && pending == 0) begin
          r.status = ptd_pkg::ST_NONE_DUE;
        end else begin
          p = scan_on ? int'(scan_pos[5:0]) : 0;
          for (; p < NPRIO * 16; p++) begin
            lvl = p / 16;
            k   = p % 16;
            if (k < NSLOT && in_use[k] && pending[k] && task_prio[k] == lvl &&
                task_mode[k] == ptd_pkg::MODE_READY) begin
              pending[k]   = 1'b0;
              task_mode[k] = ptd_pkg::MODE_RUNNING;
              busy         = 1'b1;
              busy_slot    = 4'(k);
              run_from     = tick_count;
              r.rslot      = 4'(k);
              found        = 1'b1;
              p++;
              break;
            end
          end
          if (found && p < NPRIO * 16) begin
            scan_on  = 1'b1;
            scan_pos = 7'(p);
          end else begin
            scan_on = 1'b0;
            if (!found) r.status = ptd_pkg::ST_NONE_DUE;
          end
        end
      end
      ptd_pkg::OP_DONE: begin
        if (!busy) begin
          r.status = ptd_pkg::ST_NOT_RUN;
        end else begin
          r.run = tick_count - run_from;
          if (r.run > task_peak[busy_slot]) task_peak[busy_slot] = r.run;
          r.peak = task_peak[busy_slot];
          task_start[busy_slot] = tick_count;
          if (task_mode[busy_slot] == ptd_pkg::MODE_RUNNING)
            task_mode[busy_slot] = ptd_pkg::MODE_READY;
          busy    = 1'b0;
          r.rslot = busy_slot;
        end
      end
      default: ;
    endcase
    r.now = tick_count;
    return r;
  endfunction

  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // send one transaction and record its predicted result on acceptance
  task automatic send_op(logic [3:0] op, logic [3:0] s = 4'd0, logic [31:0] per = 32'd0,
                         logic [1:0] pr = 2'd0);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.slot         <= s;
    in_ch.period_ticks <= per;
    in_ch.prio_level   <= pr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(dispatcher_step(op, s, per, pr));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall per transaction plus an optional long hold-off
  initial begin
    int gap;
    gap = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        gap = idle_draw();
        out_ch.ready <= (gap == 0);
      end else if (gap > 0) begin
        gap--;
        out_ch.ready <= (gap == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status);
          fails++;
        end
        if (out_ch.result_slot !== e.rslot) begin
          $error("result_slot: expected %0d, got %0d", e.rslot, out_ch.result_slot);
          fails++;
        end
        if (out_ch.run_ticks !== e.run) begin
          $error("run_ticks: expected %0d, got %0d", e.run, out_ch.run_ticks);
          fails++;
        end
        if (out_ch.peak_run_ticks !== e.peak) begin
          $error("peak_run_ticks: expected %0d, got %0d", e.peak, out_ch.peak_run_ticks);
          fails++;
        end
        if (out_ch.clock_now !== e.now) begin
          $error("clock_now: expected %0d, got %0d", e.now, out_ch.clock_now);
          fails++;
        end
      end
    end
  end

  // empty table: done, dispatch, tick, unknown opcodes
  task automatic test_idle_table();
    send_op(ptd_pkg::OP_DONE);
    send_op(ptd_pkg::OP_DISPATCH);
    send_op(ptd_pkg::OP_TICK);
    for (int i = 1; i <= 7; i++) send_op(4'(ptd_pkg::OP_DONE) + 4'(i));
  endtask

  // fill the table with extreme periods and priorities, then overflow
  task automatic test_table_full();
    send_op(ptd_pkg::OP_ADD, 4'd0, 32'd0, 2'd0);
    send_op(ptd_pkg::OP_ADD, 4'd0, 32'hFFFF_FFFF, 2'd3);
    for (int i = 2; i < NSLOT; i++) send_op(ptd_pkg::OP_ADD, 4'd0, 32'(i % 3), 2'(i));
    send_op(ptd_pkg::OP_ADD, 4'd15, 32'd1, 2'd1);
  endtask

  // slot edits, on used and free slots
  task automatic test_slot_edits();
    send_op(ptd_pkg::OP_REMOVE, 4'd15);
    send_op(ptd_pkg::OP_SUSPEND, 4'd15);
    send_op(ptd_pkg::OP_SET_PER, 4'd15, 32'd5);
    send_op(ptd_pkg::OP_SET_PRIO, 4'd15, 32'd0, 2'd2);
    send_op(ptd_pkg::OP_RESUME, 4'd15);
    send_op(ptd_pkg::OP_SUSPEND, 4'd3);
    send_op(ptd_pkg::OP_SET_PRIO, 4'd2, 32'd0, 2'd0);
    send_op(ptd_pkg::OP_REMOVE, 4'd4);
  endtask

  // dispatch scan, dispatch while running, suspend while running, done
  task automatic test_dispatch_cycle();
    repeat (3) send_op(ptd_pkg::OP_TICK);
    send_op(ptd_pkg::OP_DISPATCH);
    send_op(ptd_pkg::OP_DISPATCH);
    send_op(ptd_pkg::OP_TICK);
    send_op(ptd_pkg::OP_SUSPEND, 4'd0);
    send_op(ptd_pkg::OP_DONE);
    send_op(ptd_pkg::OP_DISPATCH);
    send_op(ptd_pkg::OP_TICK);
    send_op(ptd_pkg::OP_DONE);
    send_op(ptd_pkg::OP_DONE);
  endtask

  // receiver holds off while the sender keeps offering transactions
  task automatic test_backpressure();
    wait_drained();
    rx_hold = 300;
    quiet = 1'b1;
    repeat (8) send_op(ptd_pkg::OP_TICK);
    quiet = 1'b0;
  endtask

  function automatic logic [3:0] pick_op();
    int w;
    w = $urandom_range(0, 99);
    if (w < 30) return ptd_pkg::OP_TICK;
    if (w < 40) return ptd_pkg::OP_ADD;
    if (w < 46) return ptd_pkg::OP_REMOVE;
    if (w < 50) return ptd_pkg::OP_SUSPEND;
    if (w < 55) return ptd_pkg::OP_RESUME;
    if (w < 59) return ptd_pkg::OP_SET_PER;
    if (w < 63) return ptd_pkg::OP_SET_PRIO;
    if (w < 81) return ptd_pkg::OP_DISPATCH;
    if (w < 96) return ptd_pkg::OP_DONE;
    return 4'($urandom_range(int'(ptd_pkg::OP_DONE) + 1, 15));
  endfunction

  // random mix of ticks, dispatch/done and slot management
  task automatic test_random_mix(int count);
    logic [31:0] per;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n == count / 2) begin
        // sender waits for every outstanding result
        wait_drained();
      end
      per = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 6));
      send_op(pick_op(), 4'($urandom_range(0, 15)), per, 2'($urandom_range(0, 3)));
    end
    quiet = 1'b0;
  endtask

  initial begin
    int waited;
    fails = 0;
    quiet = 1'b0;
    rx_hold = 0;
    tick_count = '0;
    in_use = '0;
    pending = '0;
    for (int i = 0; i < NSLOT; i++) begin
      task_mode[i]   = ptd_pkg::MODE_SUSPENDED;
      task_period[i] = '0;
      task_start[i]  = '0;
      task_prio[i]   = '0;
      task_peak[i]   = '0;
    end
    run_from = '0;
    busy = 1'b0;
    busy_slot = '0;
    scan_on = 1'b0;
    scan_pos = '0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.opcode = ptd_pkg::OP_TICK;
    in_ch.slot = '0;
    in_ch.period_ticks = '0;
    in_ch.prio_level = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_idle_table();
    test_table_full();
    test_slot_edits();
    test_dispatch_cycle();
    test_backpressure();
    test_random_mix(395);

    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
